/* design/cti_pkg.sv */
`timescale 1ns / 1ps
package cti_pkg;

  // one in unsigned or signed Q16.16
  localparam int ONE_Q16 = 65536;

  // sample width and width of the signed fraction d, which spans [-1.0, 1.0]
  localparam int Y_W = 32;
  localparam int D_W = 18;

  // request kinds
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // control from the position stages into the banked table
  typedef struct packed {
    logic rd;   // query lookup this cycle
    logic wr;   // sample write this cycle, index already range-checked
    logic oor;  // position saturated at the table end
  } addr_ctl_t;

  // control from the table into the evaluation pipeline
  typedef struct packed {
    logic valid;
    logic oor;
  } eval_ctl_t;

endpackage

/* design/cubic_table_interpolator.sv */
`timescale 1ns / 1ps
// Cubic table interpolator. Write requests (kind 0) load signed Q16.16 samples into a
// TABLE_DEPTH entry table; query requests (kind 1) scale the radius by inverse_spacing
// and return the Newton forward difference cubic through the four neighboring samples,
// saturated to Q16.16, with out_of_range set when the position ran past the table end.
// One request is taken every clock cycle; busy is high only while rst is. A query's result
// appears on interpolated / out_of_range with result_valid high for exactly one cycle,
// after the eleven register stages of the pipeline (request capture, position multiply,
// index split, banked table read, differences, and three multiply / round-and-add
// pairs). Results cannot be held off, so a consumer must take each one in its cycle. The
// table is split into four interleaved banks with one write and one read port each, so
// the four neighbors come out in the same cycle; writes flow through the same pipeline
// and take effect in request order. Samples never written read as unknown values, and
// there is no clearing pass after reset. Write inverse_spacing only when no query is in
// flight.
module cubic_table_interpolator
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [9:0]            write_index,
  input  logic signed [Y_W-1:0] write_value,
  input  logic [31:0]           radius,
  input  logic                  cfg_write,
  input  logic [31:0]           cfg_data,
  output logic                  result_valid,
  output logic signed [Y_W-1:0] interpolated,
  output logic                  out_of_range
);

  localparam int IW      = $clog2(TABLE_DEPTH);
  localparam int LATENCY = 11;

  logic                  accept;
  addr_ctl_t             addr_ctl;
  logic signed [D_W-1:0] addr_d;
  logic [IW-1:0]         addr_base;
  logic [IW-1:0]         addr_wr_index;
  logic signed [Y_W-1:0] addr_wr_value;
  eval_ctl_t             tbl_ctl;
  logic signed [D_W-1:0] tbl_d;
  logic signed [Y_W-1:0] tbl_ym;
  logic signed [Y_W-1:0] tbl_y0;
  logic signed [Y_W-1:0] tbl_y1;
  logic signed [Y_W-1:0] tbl_y2;

  // the pipeline never stalls
  assign busy   = rst;
  assign accept = start && !busy;

  // position and index split
  cti_addr #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .write_index(write_index),
    .write_value(write_value),
    .radius     (radius),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .ctl        (addr_ctl),
    .d          (addr_d),
    .base       (addr_base),
    .wr_index   (addr_wr_index),
    .wr_value   (addr_wr_value)
  );

  // banked sample table
  cti_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (addr_ctl),
    .d       (addr_d),
    .base    (addr_base),
    .wr_index(addr_wr_index),
    .wr_value(addr_wr_value),
    .eval_ctl(tbl_ctl),
    .eval_d  (tbl_d),
    .ym      (tbl_ym),
    .y0      (tbl_y0),
    .y1      (tbl_y1),
    .y2      (tbl_y2)
  );

  // cubic evaluation
  cti_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .ctl         (tbl_ctl),
    .d           (tbl_d),
    .ym          (tbl_ym),
    .y0          (tbl_y0),
    .y1          (tbl_y1),
    .y2          (tbl_y2),
    .result_valid(result_valid),
    .interpolated(interpolated),
    .out_of_range(out_of_range)
  );

  // every result traces back to an accepted query
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept && (kind == KIND_QUERY), LATENCY))
    else $error("result without a matching query");

  // a write request never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_WRITE)) |-> ##LATENCY !result_valid)
    else $error("result produced for a write request");

  // a zero radius sits below the table, never past its end
  a_zero_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(radius == 32'd0, LATENCY)) |-> !out_of_range)
    else $error("zero radius flagged out of range");

endmodule

/* design/cti_addr.sv */
`timescale 1ns / 1ps
module cti_addr
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  kind,
  input  logic [9:0]            write_index,
  input  logic signed [Y_W-1:0] write_value,
  input  logic [31:0]           radius,
  input  logic                  cfg_write,
  input  logic [31:0]           cfg_data,
  output addr_ctl_t             ctl,
  output logic signed [D_W-1:0] d,
  output logic [IW-1:0]         base,
  output logic [IW-1:0]         wr_index,
  output logic signed [Y_W-1:0] wr_value
);

  // inverse spacing register
  logic [31:0] inverse_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_spacing <= 32'(ONE_Q16);
    end else if (cfg_write) begin
      inverse_spacing <= cfg_data;
    end
  end

  // request capture
  logic                  a_valid;
  kind_t                 a_kind;
  logic [9:0]            a_windex;
  logic signed [Y_W-1:0] a_wvalue;
  logic [31:0]           a_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_kind   <= kind_t'(kind);
    a_windex <= write_index;
    a_wvalue <= write_value;
    a_radius <= radius;
  end

  // position = radius * inverse spacing, Q32.32
  logic                  b_valid;
  kind_t                 b_kind;
  logic [9:0]            b_windex;
  logic signed [Y_W-1:0] b_wvalue;
  logic [63:0]           b_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_kind   <= a_kind;
    b_windex <= a_windex;
    b_wvalue <= a_wvalue;
    b_pos    <= a_radius * inverse_spacing;
  end

  // split into index and fraction, clamp at both table ends
  logic [31:0]           ipart;
  logic [15:0]           frac;
  logic                  under;
  logic                  over;
  logic signed [D_W-1:0] d_c;
  logic [IW-1:0]         base_c;
  logic                  wr_c;

  always_comb begin
    ipart = b_pos[63:32];
    frac  = b_pos[31:16];
    under = (ipart == '0);
    over  = (ipart > 32'(TABLE_DEPTH - 3));
    if (under) begin
      // backward extrapolation around index one
      d_c    = D_W'($signed({1'b0, frac})) - D_W'(ONE_Q16);
      base_c = '0;
    end else if (over) begin
      d_c    = D_W'(ONE_Q16);
      base_c = IW'(TABLE_DEPTH - 4);
    end else begin
      d_c    = D_W'($signed({1'b0, frac}));
      base_c = IW'(ipart - 32'd1);
    end
    wr_c = b_valid && (b_kind == KIND_WRITE) && (32'(b_windex) < 32'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.rd  <= b_valid && (b_kind == KIND_QUERY);
      ctl.wr  <= wr_c;
      ctl.oor <= over;
    end
    d        <= d_c;
    base     <= base_c;
    wr_index <= IW'(b_windex);
    wr_value <= b_wvalue;
  end

endmodule

/* design/cti_table.sv */
`timescale 1ns / 1ps
module cti_table
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  addr_ctl_t             ctl,
  input  logic signed [D_W-1:0] d,
  input  logic [IW-1:0]         base,
  input  logic [IW-1:0]         wr_index,
  input  logic signed [Y_W-1:0] wr_value,
  output eval_ctl_t             eval_ctl,
  output logic signed [D_W-1:0] eval_d,
  output logic signed [Y_W-1:0] ym,
  output logic signed [Y_W-1:0] y0,
  output logic signed [Y_W-1:0] y1,
  output logic signed [Y_W-1:0] y2
);

  // four banks interleaved on the low address bits, so four neighbors hit each bank once
  localparam int BANKS  = 4;
  localparam int LANE_W = 2;
  localparam int ROWS   = (TABLE_DEPTH + BANKS - 1) / BANKS;
  localparam int ROW_W  = (IW > LANE_W) ? IW - LANE_W : 1;

  logic signed [Y_W-1:0] bank_q [BANKS];
  logic [LANE_W-1:0]     rot;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic signed [Y_W-1:0] mem [ROWS];
    logic signed [Y_W-1:0] q;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      wr_row;

    // banks below the base lane take their neighbor from the next row
    assign rd_row = ROW_W'(base >> LANE_W) + ROW_W'(LANE_W'(b) < base[LANE_W-1:0]);
    assign wr_row = ROW_W'(wr_index >> LANE_W);

    always_ff @(posedge clk) begin
      if (ctl.wr && (wr_index[LANE_W-1:0] == LANE_W'(b))) begin
        mem[wr_row] <= wr_value;
      end
      if (ctl.rd) begin
        q <= mem[rd_row];
      end
    end

    assign bank_q[b] = q;
  end

  // control and fraction travel alongside the read
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_ctl <= '0;
    end else begin
      eval_ctl.valid <= ctl.rd;
      eval_ctl.oor   <= ctl.oor;
    end
    eval_d <= d;
    rot    <= base[LANE_W-1:0];
  end

  // put the bank outputs back in address order
  assign ym = bank_q[rot];
  assign y0 = bank_q[LANE_W'(rot + 2'd1)];
  assign y1 = bank_q[LANE_W'(rot + 2'd2)];
  assign y2 = bank_q[LANE_W'(rot + 2'd3)];

endmodule

/* design/cti_eval.sv */
`timescale 1ns / 1ps
module cti_eval
  import cti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  eval_ctl_t             ctl,
  input  logic signed [D_W-1:0] d,
  input  logic signed [Y_W-1:0] ym,
  input  logic signed [Y_W-1:0] y0,
  input  logic signed [Y_W-1:0] y1,
  input  logic signed [Y_W-1:0] y2,
  output logic                  result_valid,
  output logic signed [Y_W-1:0] interpolated,
  output logic                  out_of_range
);

  localparam int G1_W = Y_W + 1;
  localparam int H2_W = Y_W + 2;
  localparam int I2_W = Y_W + 3;
  localparam int S2_W = Y_W + 4;
  localparam int S1_W = Y_W + 5;
  localparam int R_W  = Y_W + 6;
  localparam int P3_W = D_W + I2_W;
  localparam int P2_W = D_W + S2_W;
  localparam int P1_W = D_W + S1_W;

  // divide by three as multiply by ceil(2^19 / 3), exact below 2^19
  localparam int               THIRD_SHIFT = 19;
  localparam logic [D_W-1:0]   THIRD_MUL   = D_W'(((1 << THIRD_SHIFT) + 2) / 3);
  localparam logic signed [D_W:0]   DM_BIAS = (D_W + 1)'(2 * ONE_Q16 + 1);
  localparam logic signed [D_W-1:0] D_ONE   = D_W'(ONE_Q16);

  // rounding offsets, half away from zero
  localparam logic signed [P3_W-1:0] RND3 = P3_W'(1 << 15);
  localparam logic signed [P2_W-1:0] RND2 = P2_W'(1 << 16);
  localparam logic signed [P1_W-1:0] RND1 = P1_W'(1 << 15);

  // forward differences and dm
  logic signed [G1_W-1:0]  g1_c;
  logic signed [H2_W-1:0]  h2_c;
  logic signed [I2_W-1:0]  i2_c;
  logic signed [D_W:0]     num_s;
  logic [D_W-1:0]          num;
  logic [2*D_W-1:0]        third_prod;
  logic signed [D_W-1:0]   dm_c;

  always_comb begin
    // h2 = (y2 - y1) - g1, i2 = (y2 - ym) - 3 * g1
    g1_c = G1_W'(y1) - G1_W'(y0);
    h2_c = (H2_W'(y2) - H2_W'(y1)) - H2_W'(g1_c);
    i2_c = (I2_W'(y2) - I2_W'(ym)) - (I2_W'(g1_c) + (I2_W'(g1_c) <<< 1));
    num_s      = DM_BIAS - (D_W + 1)'(d);
    num        = num_s[D_W-1:0];
    third_prod = num * THIRD_MUL;
    dm_c       = -$signed(D_W'(third_prod >> THIRD_SHIFT));
  end

  eval_ctl_t              dif_ctl;
  logic signed [D_W-1:0]  dif_d;
  logic signed [D_W-1:0]  dif_d1;
  logic signed [D_W-1:0]  dif_dm;
  logic signed [Y_W-1:0]  dif_y0;
  logic signed [G1_W-1:0] dif_g1;
  logic signed [H2_W-1:0] dif_h2;
  logic signed [I2_W-1:0] dif_i2;

  always_ff @(posedge clk) begin
    if (rst) begin
      dif_ctl <= '0;
    end else begin
      dif_ctl <= ctl;
    end
    dif_d  <= d;
    dif_d1 <= d - D_ONE;
    dif_dm <= dm_c;
    dif_y0 <= y0;
    dif_g1 <= g1_c;
    dif_h2 <= h2_c;
    dif_i2 <= i2_c;
  end

  // dm * i2
  eval_ctl_t              m3_ctl;
  logic signed [D_W-1:0]  m3_d;
  logic signed [D_W-1:0]  m3_d1;
  logic signed [Y_W-1:0]  m3_y0;
  logic signed [G1_W-1:0] m3_g1;
  logic signed [H2_W-1:0] m3_h2;
  logic signed [P3_W-1:0] m3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_ctl <= '0;
    end else begin
      m3_ctl <= dif_ctl;
    end
    m3_d    <= dif_d;
    m3_d1   <= dif_d1;
    m3_y0   <= dif_y0;
    m3_g1   <= dif_g1;
    m3_h2   <= dif_h2;
    m3_prod <= dif_dm * dif_i2;
  end

  // s2 = h2 + round(dm * i2 / 2^16)
  logic signed [P3_W-1:0] neg3;
  logic signed [P3_W-1:0] p3_adj;
  logic signed [I2_W-1:0] t3;

  always_comb begin
    neg3   = {{(P3_W-1){1'b0}}, m3_prod[P3_W-1]};
    p3_adj = m3_prod + RND3 - neg3;
    t3     = I2_W'(p3_adj >>> 16);
  end

  eval_ctl_t              s2_ctl;
  logic signed [D_W-1:0]  s2_d;
  logic signed [D_W-1:0]  s2_d1;
  logic signed [Y_W-1:0]  s2_y0;
  logic signed [G1_W-1:0] s2_g1;
  logic signed [S2_W-1:0] s2_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= m3_ctl;
    end
    s2_d   <= m3_d;
    s2_d1  <= m3_d1;
    s2_y0  <= m3_y0;
    s2_g1  <= m3_g1;
    s2_val <= S2_W'(m3_h2) + S2_W'(t3);
  end

  // (d - 1) * s2
  eval_ctl_t              m2_ctl;
  logic signed [D_W-1:0]  m2_d;
  logic signed [Y_W-1:0]  m2_y0;
  logic signed [G1_W-1:0] m2_g1;
  logic signed [P2_W-1:0] m2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_ctl <= '0;
    end else begin
      m2_ctl <= s2_ctl;
    end
    m2_d    <= s2_d;
    m2_y0   <= s2_y0;
    m2_g1   <= s2_g1;
    m2_prod <= s2_d1 * s2_val;
  end

  // s1 = g1 + round((d - 1) * s2 / 2^17)
  logic signed [P2_W-1:0] neg2;
  logic signed [P2_W-1:0] p2_adj;
  logic signed [S2_W-1:0] t2;

  always_comb begin
    neg2   = {{(P2_W-1){1'b0}}, m2_prod[P2_W-1]};
    p2_adj = m2_prod + RND2 - neg2;
    t2     = S2_W'(p2_adj >>> 17);
  end

  eval_ctl_t              s1_ctl;
  logic signed [D_W-1:0]  s1_d;
  logic signed [Y_W-1:0]  s1_y0;
  logic signed [S1_W-1:0] s1_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= m2_ctl;
    end
    s1_d   <= m2_d;
    s1_y0  <= m2_y0;
    s1_val <= S1_W'(m2_g1) + S1_W'(t2);
  end

  // d * s1
  eval_ctl_t              m1_ctl;
  logic signed [Y_W-1:0]  m1_y0;
  logic signed [P1_W-1:0] m1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_ctl <= '0;
    end else begin
      m1_ctl <= s1_ctl;
    end
    m1_y0   <= s1_y0;
    m1_prod <= s1_d * s1_val;
  end

  // y0 + round(d * s1 / 2^16), saturated to 32 bits
  logic signed [P1_W-1:0] neg1;
  logic signed [P1_W-1:0] p1_adj;
  logic signed [S1_W-1:0] t1;
  logic signed [R_W-1:0]  sum;
  logic signed [Y_W-1:0]  sat_c;

  always_comb begin
    neg1   = {{(P1_W-1){1'b0}}, m1_prod[P1_W-1]};
    p1_adj = m1_prod + RND1 - neg1;
    t1     = S1_W'(p1_adj >>> 16);
    sum    = R_W'(m1_y0) + R_W'(t1);
    if ((sum[R_W-1:Y_W-1] == '0) || (sum[R_W-1:Y_W-1] == '1)) begin
      sat_c = sum[Y_W-1:0];
    end else if (sum[R_W-1]) begin
      sat_c = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= m1_ctl.valid;
    end
    interpolated <= sat_c;
    out_of_range <= m1_ctl.oor;
  end

endmodule

/* test/cubic_table_interpolator_test.sv */
`timescale 1ns / 1ps
module cubic_table_interpolator_test;
  import cti_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LATENCY = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 110;

  // one expected interpolation result
  typedef struct packed {
    logic signed [31:0] value;
    logic               oor;
  } interp_result_t;

  // mirror of the sample table and spacing, predicts each query result
  class interp_scoreboard;
    int             samples [DEPTH];
    bit [31:0]      spacing;
    interp_result_t pending[$];
    int             errors;

    function new();
      spacing = ONE_Q16;
      errors = 0;
    endfunction

    // product scaled down by 2^shift, rounded half away from zero
    static function longint round_scaled(longint a, longint b, int shift);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 << (shift - 1))) >> shift;
      return (p < 0) ? -m : m;
    endfunction

    function interp_result_t predict(bit [31:0] rad);
      bit [63:0]      pos;
      longint         ipart, frac, ic, d;
      longint         ym, y0, y1, y2, g0, g1, g2, h1, h2, i2, dm, s1, s2, r;
      interp_result_t res;
      pos = {32'd0, rad} * {32'd0, spacing};
      ipart = longint'(pos[63:32]);
      frac = longint'(pos[31:16]);
      res.oor = 1'b0;
      // below one extrapolates backward, past the end saturates at d = 1
      if (ipart == 0) begin
        ic = 1;
        d = frac - ONE_Q16;
      end else if (ipart > DEPTH - 3) begin
        ic = DEPTH - 3;
        d = ONE_Q16;
        res.oor = 1'b1;
      end else begin
        ic = ipart;
        d = frac;
      end
      ym = samples[ic - 1];
      y0 = samples[ic];
      y1 = samples[ic + 1];
      y2 = samples[ic + 2];
      // forward differences
      g0 = y0 - ym;
      g1 = y1 - y0;
      g2 = y2 - y1;
      h1 = g1 - g0;
      h2 = g2 - g1;
      i2 = h2 - h1;
      // horner evaluation of the newton cubic
      dm = -(((2 * ONE_Q16 - d) + 1) / 3);
      s2 = h2 + round_scaled(dm, i2, 16);
      s1 = g1 + round_scaled(d - ONE_Q16, s2, 17);
      r = y0 + round_scaled(d, s1, 16);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.value = r[31:0];
      return res;
    endfunction

    function void note_request(kind_t k, bit [9:0] idx, bit [31:0] val, bit [31:0] rad);
      if (k == KIND_WRITE) begin
        samples[idx] = int'(val);
      end else begin
        pending.push_back(predict(rad));
      end
    endfunction

    function void check_result(logic signed [31:0] got_value, logic got_oor);
      interp_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d oor %b",
                 $time, got_value, got_oor);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got_value !== exp_res.value) begin
        $display("%0t: interpolated mismatch, expected %0d, got %0d",
                 $time, exp_res.value, got_value);
        errors++;
      end
      if (got_oor !== exp_res.oor) begin
        $display("%0t: out_of_range mismatch, expected %b, got %b",
                 $time, exp_res.oor, got_oor);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               kind = 1'b0;
  logic [9:0]         write_index = '0;
  logic signed [31:0] write_value = '0;
  logic [31:0]        radius = '0;
  logic               cfg_write = 1'b0;
  logic [31:0]        cfg_data = '0;
  logic               result_valid;
  logic signed [31:0] interpolated;
  logic               out_of_range;

  interp_scoreboard sb = new();
  int               cycles = 0;

  cubic_table_interpolator #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .write_index  (write_index),
    .write_value  (write_value),
    .radius       (radius),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .interpolated (interpolated),
    .out_of_range (out_of_range)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(interpolated, out_of_range);
  end

  // present one request and hold it until taken
  task automatic send_request(input kind_t k, input logic [9:0] idx,
                              input logic [31:0] val, input logic [31:0] rad);
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    write_index <= idx;
    write_value <= val;
    radius <= rad;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(k, idx, val, rad);
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending, wait out every pending result, then the pipeline tail
  task automatic wait_results(input int tail);
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic set_spacing(input logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.spacing = v;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // radius that lands mostly inside the table under the given spacing
  function automatic logic [31:0] aim_radius(bit [31:0] inv);
    bit [63:0] target;
    bit [63:0] q;
    case ($urandom_range(0, 9))
      0: target = {32'd0, $urandom};
      1: target = {32'($urandom_range(DEPTH - 2, DEPTH + 50)), $urandom};
      2: return $urandom;
      default: target = {32'($urandom_range(1, DEPTH - 3)), $urandom};
    endcase
    if (inv == 0) return $urandom;
    q = target / {32'd0, inv};
    if (q > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  initial begin
    int        level;
    int        idle_pct;
    bit [31:0] spacings [6];

    level = 0;
    spacings = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_4000,
                 $urandom, 32'h0010_0000};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    set_spacing(ONE_Q16);

    // load the whole table so no query reads an unwritten entry
    for (int i = 0; i < DEPTH; i++) begin
      if ($urandom_range(0, 6) == 0) level = pick_sample();
      else level += $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      send_request(KIND_WRITE, i[9:0], level, $urandom);
    end

    // table edges, backward extrapolation, saturation at the end
    send_request(KIND_QUERY, '0, '0, 32'h0000_0000);
    send_request(KIND_QUERY, '0, '0, 32'h0000_8000);
    send_request(KIND_QUERY, '0, '0, 32'h0001_0000);
    send_request(KIND_QUERY, '0, '0, 32'h0001_FFFF);
    send_request(KIND_QUERY, '0, '0, 32'h03FD_0000);
    send_request(KIND_QUERY, '0, '0, 32'h03FD_FFFF);
    send_request(KIND_QUERY, '0, '0, 32'h03FE_0000);
    send_request(KIND_QUERY, '0, '0, 32'hFFFF_FFFF);
    // alternating extremes drive the result into saturation
    send_request(KIND_WRITE, 10'd499, 32'h8000_0000, '0);
    send_request(KIND_WRITE, 10'd500, 32'h7FFF_FFFF, '0);
    send_request(KIND_WRITE, 10'd501, 32'h8000_0000, '0);
    send_request(KIND_WRITE, 10'd502, 32'h7FFF_FFFF, '0);
    send_request(KIND_QUERY, '0, '0, 32'h01F4_8000);
    send_request(KIND_QUERY, '0, '0, 32'h01F4_FFFF);
    send_request(KIND_WRITE, 10'd499, 32'h7FFF_FFFF, '0);
    send_request(KIND_WRITE, 10'd501, 32'h7FFF_FFFF, '0);
    send_request(KIND_QUERY, '0, '0, 32'h01F4_4000);
    send_request(KIND_WRITE, 10'd0, 32'h8000_0000, '0);
    send_request(KIND_WRITE, 10'd1, 32'h7FFF_FFFF, '0);
    send_request(KIND_QUERY, '0, '0, 32'h0000_0000);
    send_request(KIND_WRITE, 10'd1023, 32'h8000_0000, '0);
    send_request(KIND_QUERY, '0, '0, 32'h1234_5678);

    // random phases, one spacing each
    for (int ph = 0; ph < 6; ph++) begin
      wait_results(LATENCY + 3);
      set_spacing(spacings[ph]);
      idle_pct = (ph < 2) ? 11 : (ph < 4) ? 67 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) wait_results(0);
        // each cycle idles with the phase's probability
        while ($urandom_range(0, 99) < idle_pct) pause(1);
        if ($urandom_range(0, 99) < 35) begin
          send_request(KIND_WRITE, 10'($urandom), pick_sample(), $urandom);
        end else begin
          send_request(KIND_QUERY, 10'($urandom), $urandom, aim_radius(sb.spacing));
        end
      end
    end

    wait_results(LATENCY + 5);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/cti_pkg.sv
design/cti_addr.sv
design/cti_table.sv
design/cti_eval.sv
design/cubic_table_interpolator.sv
test/cubic_table_interpolator_test.sv
